// ----- sv/hdx_pkg.sv -----
package hdx_pkg;

	localparam int TIME_BITS = 32;
	localparam int MS_PER_S = 1000;
	localparam int HOLD_MS_W = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [TIME_BITS-1:0] tstamp_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [1:0] phase_t;
	typedef logic [1:0] act_t;

	localparam cfg_idx_t CFG_HOLD_DELAY = 3'd0;
	localparam cfg_idx_t CFG_DEBOUNCE = 3'd1;
	localparam cfg_idx_t CFG_TOUCH_THRESH = 3'd2;
	localparam cfg_idx_t CFG_TOUCH_HOLD = 3'd3;
	localparam cfg_idx_t CFG_TOUCH_OVERRIDE = 3'd4;

	localparam phase_t PH_OFF = 2'd0;
	localparam phase_t PH_GOING_OFF = 2'd1;
	localparam phase_t PH_GOING_ON = 2'd2;
	localparam phase_t PH_ON = 2'd3;

	localparam act_t ACT_NONE = 2'd0;
	localparam act_t ACT_START = 2'd1;
	localparam act_t ACT_STOP = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST = 16'd200;
	localparam logic [15:0] TOUCH_THRESH_RST = 16'd50;
	localparam logic [15:0] TOUCH_HOLD_RST = 16'd500;

endpackage

// ----- sv/hdx_sample_if.sv -----
interface hdx_sample_if;
	logic valid;
	logic ready;
	logic [31:0] now_ms;
	logic hook_level;
	logic [15:0] touch_value;

	modport source (output valid, output now_ms, output hook_level, output touch_value,
		input ready);
	modport sink (input valid, input now_ms, input hook_level, input touch_value,
		output ready);
endinterface

// ----- sv/hdx_result_if.sv -----
interface hdx_result_if;
	logic valid;
	logic ready;
	logic heater_on;
	logic [1:0] hook_action;
	logic [1:0] touch_action;
	logic forced_on;
	logic [1:0] hook_state;

	modport source (output valid, output heater_on, output hook_action, output touch_action,
		output forced_on, output hook_state, input ready);
	modport sink (input valid, input heater_on, input hook_action, input touch_action,
		input forced_on, input hook_state, output ready);
endinterface

// ----- sv/hook_debounce_extractor_controller_unit.sv -----
// Debounces the holder hook sensor and the touch pad and issues heater and extractor
// commands. One sample beat is accepted every clock cycle unless the input stalls, and each
// sample yields exactly one result beat, held first in the input register and then passed to the
// decision logic that writes the result register and the controller state. While a result
// waits, the input register still takes one more sample, after which the input stalls
// until the waiting result is taken.
// Registers may be written only while no sample is in flight.
module hook_debounce_extractor_controller_unit (
	input logic clk,
	input logic arst_n,
	hdx_sample_if.sink sample,
	hdx_result_if.source result,
	input logic cfg_we,
	input hdx_pkg::cfg_idx_t cfg_idx,
	input hdx_pkg::cfg_data_t cfg_wdata
);
	import hdx_pkg::*;

	logic [HOLD_MS_W-1:0] hold_ms_q;
	logic [15:0] debounce_q;
	logic [15:0] thresh_q;
	logic [15:0] touch_hold_q;
	logic override_q;

	logic valid_s1;
	tstamp_t now_s1;
	logic level_s1;
	logic [15:0] touch_s1;

	phase_t phase_q;
	tstamp_t phase_start_q;
	tstamp_t deadline_q;
	logic armed_q;
	logic heater_q;
	tstamp_t touch_start_q;
	logic touch_active_q;
	logic handled_q;
	logic forced_q;

	logic res_valid_q;
	logic res_heater_q;
	act_t res_hook_act_q;
	act_t res_touch_act_q;
	logic res_forced_q;
	phase_t res_phase_q;

	logic advance;
	phase_t ph1, ph2;
	tstamp_t pst1;
	tstamp_t el;
	logic deb_over;
	logic heater_nx;
	logic armed1, armed_nx;
	tstamp_t dl1;
	logic just_armed;
	tstamp_t past;
	logic passed;
	logic forced1, forced_nx;
	act_t hook_act;
	act_t touch_act;
	logic touched, released, fire;
	tstamp_t touch_el;

	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms_q <= '0;
			debounce_q <= DEBOUNCE_RST;
			thresh_q <= TOUCH_THRESH_RST;
			touch_hold_q <= TOUCH_HOLD_RST;
			override_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HOLD_DELAY: begin
					hold_ms_q <= HOLD_MS_W'({10'd0, cfg_wdata} * HOLD_MS_W'(MS_PER_S));
				end
				CFG_DEBOUNCE: debounce_q <= cfg_wdata;
				CFG_TOUCH_THRESH: thresh_q <= cfg_wdata;
				CFG_TOUCH_HOLD: touch_hold_q <= cfg_wdata;
				CFG_TOUCH_OVERRIDE: override_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_s1 <= TIME_BITS'(sample.now_ms);
			level_s1 <= sample.hook_level;
			touch_s1 <= sample.touch_value;
		end
	end

	always_comb begin
		ph1 = phase_q;
		pst1 = phase_start_q;
		if (level_s1 && phase_q == PH_ON) begin
			ph1 = PH_GOING_OFF;
			pst1 = now_s1;
		end else if (!level_s1 && phase_q == PH_OFF) begin
			ph1 = PH_GOING_ON;
			pst1 = now_s1;
		end else if (!level_s1 && phase_q == PH_GOING_OFF) begin
			ph1 = PH_ON;
		end else if (level_s1 && phase_q == PH_GOING_ON) begin
			ph1 = PH_OFF;
		end

		el = now_s1 - pst1;
		deb_over = el > TIME_BITS'(debounce_q);

		ph2 = ph1;
		heater_nx = heater_q;
		armed1 = armed_q;
		dl1 = deadline_q;
		just_armed = 1'b0;
		hook_act = ACT_NONE;
		if (ph1 == PH_GOING_OFF && deb_over) begin
			ph2 = PH_OFF;
			armed1 = 1'b0;
			heater_nx = 1'b1;
			if (!(override_q && forced_q)) begin
				hook_act = ACT_START;
			end
		end else if (ph1 == PH_GOING_ON && deb_over) begin
			ph2 = PH_ON;
			heater_nx = 1'b0;
			dl1 = now_s1 + TIME_BITS'(hold_ms_q);
			armed1 = 1'b1;
			just_armed = 1'b1;
		end

		// A deadline armed by this sample lies exactly the hold time ahead of now.
		past = just_armed ? (TIME_BITS'(0) - TIME_BITS'(hold_ms_q)) : (now_s1 - deadline_q);
		passed = (past != '0) && !past[TIME_BITS-1];

		armed_nx = armed1;
		forced1 = forced_q;
		if (ph2 == PH_ON && armed1 && passed) begin
			if (!override_q) begin
				hook_act = ACT_STOP;
				forced1 = 1'b0;
			end else if (!forced_q) begin
				hook_act = ACT_STOP;
			end
			armed_nx = 1'b0;
		end

		touched = touch_s1 < thresh_q;
		released = touch_s1 > thresh_q;
		touch_el = now_s1 - touch_start_q;
		fire = touched && touch_active_q && (touch_el > TIME_BITS'(touch_hold_q)) && !handled_q;
		forced_nx = fire ? !forced1 : forced1;
		touch_act = ACT_NONE;
		if (fire) begin
			touch_act = forced_nx ? ACT_START : ACT_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ON;
			armed_q <= 1'b0;
			heater_q <= 1'b0;
			touch_active_q <= 1'b0;
			handled_q <= 1'b0;
			forced_q <= 1'b0;
		end else if (advance) begin
			phase_q <= ph2;
			armed_q <= armed_nx;
			heater_q <= heater_nx;
			forced_q <= forced_nx;
			if (released) begin
				touch_active_q <= 1'b0;
				handled_q <= 1'b0;
			end else begin
				if (touched) begin
					touch_active_q <= 1'b1;
				end
				if (fire) begin
					handled_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_start_q <= pst1;
			deadline_q <= dl1;
			if (touched && !touch_active_q) begin
				touch_start_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_heater_q <= heater_nx;
			res_hook_act_q <= hook_act;
			res_touch_act_q <= touch_act;
			res_forced_q <= forced_nx;
			res_phase_q <= ph2;
		end
	end

	assign result.valid = res_valid_q;
	assign result.heater_on = res_heater_q;
	assign result.hook_action = res_hook_act_q;
	assign result.touch_action = res_touch_act_q;
	assign result.forced_on = res_forced_q;
	assign result.hook_state = res_phase_q;

	// The heater follows the confirmed hook side.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_heater_q == (res_phase_q == PH_OFF || res_phase_q == PH_GOING_ON)))
		else $error("heater level disagrees with hook state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_hook_act_q == ACT_START) |-> (res_phase_q == PH_OFF))
		else $error("hook start outside off hook");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_hook_act_q == ACT_STOP) |-> (res_phase_q == PH_ON))
		else $error("hook stop outside on hook");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_touch_act_q != ACT_NONE) |->
		(res_forced_q == (res_touch_act_q == ACT_START)))
		else $error("touch command disagrees with forced flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> res_valid_q)
		else $error("result beat dropped while stalled");

endmodule
